>>> rtl/spfm_pkg.sv
// ----------------------------------------------------------------------------
// Segment/page frame map package
// Shared sizes, codes and the word that travels along the row of cells.
// ----------------------------------------------------------------------------
package spfm_pkg;

  localparam int unsigned MODULES           = 16;
  localparam int unsigned FRAMES_PER_MODULE = 8;

  localparam int unsigned MOD_W    = 4;
  localparam int unsigned FRAME_W  = 3;
  localparam int unsigned SEL_W    = 4;
  localparam int unsigned TAG_W    = 8;
  localparam int unsigned SEG_W    = 4;
  localparam int unsigned PAGE_W   = 4;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NMOD_W   = 5;
  localparam int unsigned OSF_W    = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD_COUNT = 1'b0,
    CFG_OS_FRAMES = 1'b1
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_MAP    = 2'd1,
    FUNC_REINIT = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_MISS      = 2'd1,
    ST_NOFRAME   = 2'd2,
    ST_HARDWIRED = 2'd3
  } status_e;

  // Command word handed from cell to cell.
  typedef struct packed {
    logic               valid;
    func_e              func;
    logic [TAG_W-1:0]   tag;
    logic [MOD_W-1:0]   mod;
    logic [FRAME_W-1:0] frm;
    logic               wr;
    status_e            status;
    logic               found;
    logic [MOD_W-1:0]   hit_module;
    logic [FRAME_W-1:0] hit_frame;
  } token_t;

endpackage

>>> rtl/spfm_intf.sv
// ----------------------------------------------------------------------------
// Segment/page frame map channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface spfm_in_if;
  logic                        valid;
  logic                        ready;
  logic [spfm_pkg::FUNC_W-1:0] func;
  logic [spfm_pkg::SEG_W-1:0]  segment;
  logic [spfm_pkg::PAGE_W-1:0] page;
  logic [spfm_pkg::SEL_W-1:0]  module_sel;
  logic [spfm_pkg::SEL_W-1:0]  frame_sel;

  modport source (output valid, func, segment, page, module_sel, frame_sel, input ready);
  modport sink   (input valid, func, segment, page, module_sel, frame_sel, output ready);
endinterface

interface spfm_out_if;
  logic                          valid;
  logic                          ready;
  logic [spfm_pkg::STATUS_W-1:0] status;
  logic [spfm_pkg::MOD_W-1:0]    hit_module;
  logic [spfm_pkg::FRAME_W-1:0]  hit_frame;

  modport source (output valid, status, hit_module, hit_frame, input ready);
  modport sink   (input valid, status, hit_module, hit_frame, output ready);
endinterface

interface spfm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [spfm_pkg::CFG_IDX_W-1:0]  index;
  logic [spfm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/spfm_cell.sv
// ----------------------------------------------------------------------------
// Frame map cell
// Holds the tags of one memory module, applies map commands aimed at it and
// every reinitialize command, and folds its tag compare into passing lookups.
// ----------------------------------------------------------------------------
module spfm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [spfm_pkg::MOD_W-1:0] cell_idx_i,
  input  logic                       populated_i,
  input  logic [spfm_pkg::OSF_W-1:0] os_frames_i,
  input  spfm_pkg::token_t           token_i,
  output spfm_pkg::token_t           token_o
);
  import spfm_pkg::*;

  logic [TAG_W-1:0]             tags_q [FRAMES_PER_MODULE];
  logic [TAG_W-1:0]             tags_d [FRAMES_PER_MODULE];
  logic [FRAMES_PER_MODULE-1:0] match;
  logic [FRAME_W-1:0]           match_idx;
  token_t                       token_d;
  token_t                       token_q;

  always_comb begin
    match_idx = '0;
    for (int f = FRAMES_PER_MODULE - 1; f >= 0; f--) begin
      match[f] = (tags_q[f] == token_i.tag);
      if (match[f]) begin
        match_idx = FRAME_W'(f);
      end
    end
  end

  always_comb begin
    token_d = token_i;
    for (int f = 0; f < FRAMES_PER_MODULE; f++) begin
      tags_d[f] = tags_q[f];
    end
    if (token_i.valid) begin
      case (token_i.func)
        FUNC_LOOKUP: begin
          if (!token_i.found && populated_i && (|match)) begin
            token_d.found      = 1'b1;
            token_d.status     = ST_OK;
            token_d.hit_module = cell_idx_i;
            token_d.hit_frame  = match_idx;
          end
        end
        FUNC_MAP: begin
          if (token_i.wr && (token_i.mod == cell_idx_i)) begin
            tags_d[token_i.frm] = token_i.tag;
          end
        end
        FUNC_REINIT: begin
          // Module zero keeps its operating-system frames mapped to 0:frame.
          for (int f = 0; f < FRAMES_PER_MODULE; f++) begin
            if ((cell_idx_i == '0) && (FRAME_W'(f) < FRAME_W'(os_frames_i))) begin
              tags_d[f] = TAG_W'(f);
            end else begin
              tags_d[f] = '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= '0;
      for (int f = 0; f < FRAMES_PER_MODULE; f++) begin
        tags_q[f] <= '0;
      end
    end else if (advance_i) begin
      token_q <= token_d;
      for (int f = 0; f < FRAMES_PER_MODULE; f++) begin
        tags_q[f] <= tags_d[f];
      end
    end
  end

  assign token_o = token_q;

`ifndef SYNTHESIS
  a_hit_here: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && token_i.valid && (token_i.func == FUNC_LOOKUP) && !token_i.found
      && populated_i && (|match)
    |=> token_q.found && (token_q.hit_module == $past(cell_idx_i)))
    else $error("lookup hit in this cell not recorded");
  a_found_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && token_i.valid && token_i.found
    |=> token_q.found && (token_q.hit_module == $past(token_i.hit_module)))
    else $error("earlier hit overwritten");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(token_q))
    else $error("cell word moved during a stall");
`endif

endmodule

>>> rtl/segment_page_frame_map_core.sv
// ----------------------------------------------------------------------------
// Segment/page frame map core
// Logical-to-physical page map built as a row of per-module cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command word per handshake: lookup of segment:page,
//   map of segment:page into (module_sel, frame_sel), or reinitialize.
//   out_ch returns one result word per command, in command order: status,
//   and the module and frame of the lowest matching frame on a lookup hit.
//   cfg_ch writes the populated module count (index 0) and os_frames
//   (index 1); it is always ready and is meant to be used while no command
//   is in flight.
// Flow:
//   A command passes one cell per cycle unless the row is stalled, one
//   cell per memory module. The first cell works on the word as it is
//   accepted; the result word is presented from the last cell's register.
//   One command word is accepted per cycle unless stalled; later commands
//   see the map writes of earlier ones since every cell sees them in order.
// Reset:
//   All tags read 0:0, the module count is 1, os_frames is 1.
// Stalls:
//   While a result waits on out_ch the whole row holds and in_ch is not
//   ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_page_frame_map_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  spfm_in_if.sink     in_ch,
  spfm_out_if.source  out_ch,
  spfm_cfg_if.sink    cfg_ch
);
  import spfm_pkg::*;

  logic [NMOD_W-1:0] mod_count_q;
  logic [OSF_W-1:0]  os_frames_q;
  logic [NMOD_W-1:0] nmod;
  logic [MODULES-1:0] populated;
  logic              advance;
  logic [FRAME_W-1:0] frm_in;
  token_t            ingress;
  token_t            chain [MODULES+1];
  token_t            tail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_count_q <= NMOD_W'(1);
      os_frames_q <= OSF_W'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_e'(cfg_ch.index))
        CFG_MOD_COUNT: mod_count_q <= cfg_ch.data[NMOD_W-1:0];
        CFG_OS_FRAMES: os_frames_q <= cfg_ch.data[OSF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign nmod = (mod_count_q > NMOD_W'(MODULES)) ? NMOD_W'(MODULES) : mod_count_q;

  always_comb begin
    for (int m = 0; m < MODULES; m++) begin
      populated[m] = (NMOD_W'(m) < nmod);
    end
  end

  assign tail    = chain[MODULES];
  assign advance = !tail.valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign frm_in  = in_ch.frame_sel[FRAME_W-1:0];

  // Map checks are settled on entry; the owning cell only does the write.
  always_comb begin
    ingress            = '0;
    ingress.valid      = in_ch.valid && advance;
    ingress.func       = func_e'(in_ch.func);
    ingress.tag        = {in_ch.segment, in_ch.page};
    ingress.mod        = in_ch.module_sel;
    ingress.frm        = frm_in;
    ingress.status     = ST_OK;
    case (func_e'(in_ch.func))
      FUNC_LOOKUP: ingress.status = ST_MISS;
      FUNC_MAP: begin
        if ({1'b0, in_ch.module_sel} >= nmod) begin
          ingress.status = ST_NOFRAME;
        end else if ((in_ch.module_sel == '0) && (frm_in < FRAME_W'(os_frames_q))) begin
          ingress.status = ST_HARDWIRED;
        end else begin
          ingress.wr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign chain[0] = ingress;

  for (genvar m = 0; m < MODULES; m++) begin : g_cell
    spfm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .advance_i   (advance),
      .cell_idx_i  (MOD_W'(m)),
      .populated_i (populated[m]),
      .os_frames_i (os_frames_q),
      .token_i     (chain[m]),
      .token_o     (chain[m+1])
    );
  end

  assign out_ch.valid      = tail.valid;
  assign out_ch.status     = tail.status;
  assign out_ch.hit_module = tail.hit_module;
  assign out_ch.hit_frame  = tail.hit_frame;

`ifndef SYNTHESIS
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid && (tail.status != ST_OK) |-> (tail.hit_module == '0) && (tail.hit_frame == '0))
    else $error("hit location reported without a hit");
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid && tail.found |-> (tail.status == ST_OK) && (tail.func == FUNC_LOOKUP))
    else $error("hit carries a non-ok status");
  a_hit_populated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid && tail.found |-> ({1'b0, tail.hit_module} < nmod))
    else $error("hit in a module beyond the populated count");
`endif

endmodule

>>> verif/spfm_map_checker.sv
// ----------------------------------------------------------------------------
// Segment/page frame map checker
// Watches the command, result and register channels, keeps its own copy of
// the frame tags and registers, and compares every result word in order.
// ----------------------------------------------------------------------------
module spfm_map_checker
  import spfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  spfm_in_if          in_ch,
  spfm_out_if         out_ch,
  spfm_cfg_if         cfg_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned FRAME_COUNT = MODULES * FRAMES_PER_MODULE;
  localparam int unsigned SHOWN_LIMIT = 10;

  typedef struct packed {
    status_e            status;
    logic [MOD_W-1:0]   hit_module;
    logic [FRAME_W-1:0] hit_frame;
  } map_result_t;

  logic [TAG_W-1:0]  frame_tag [FRAME_COUNT];
  logic [NMOD_W-1:0] mod_count;
  logic [OSF_W-1:0]  os_frames;
  map_result_t       result_q [$];
  int unsigned       mismatches;
  int unsigned       result_index;

  function automatic int unsigned populated_modules();
    return (mod_count > MODULES) ? MODULES : int'(mod_count);
  endfunction

  // Clears every module, populated or not, then restores the OS frames.
  function automatic void rebuild_map();
    int unsigned i;
    for (i = 0; i < FRAME_COUNT; i++) frame_tag[i] = '0;
    for (i = 0; i < os_frames; i++) frame_tag[i] = TAG_W'(i);
  endfunction

  function automatic map_result_t apply_command(func_e func, logic [TAG_W-1:0] tag,
                                                logic [MOD_W-1:0] mod,
                                                logic [FRAME_W-1:0] frm);
    map_result_t  res;
    int unsigned  span;
    int unsigned  m;
    int unsigned  f;
    bit           found;
    res.status     = ST_OK;
    res.hit_module = '0;
    res.hit_frame  = '0;
    span  = populated_modules();
    found = 1'b0;
    case (func)
      FUNC_LOOKUP: begin
        // Module-major scan, so the lowest matching frame wins.
        for (m = 0; m < span && !found; m++) begin
          for (f = 0; f < FRAMES_PER_MODULE && !found; f++) begin
            if (frame_tag[m * FRAMES_PER_MODULE + f] == tag) begin
              found          = 1'b1;
              res.hit_module = MOD_W'(m);
              res.hit_frame  = FRAME_W'(f);
            end
          end
        end
        res.status = found ? ST_OK : ST_MISS;
      end
      FUNC_MAP: begin
        if (mod >= span) begin
          res.status = ST_NOFRAME;
        end else if (mod == 0 && frm < os_frames) begin
          res.status = ST_HARDWIRED;
        end else begin
          frame_tag[int'(mod) * FRAMES_PER_MODULE + int'(frm)] = tag;
        end
      end
      FUNC_REINIT: begin
        rebuild_map();
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t want;
    if (!rst_ni) begin
      mod_count    = 5'd1;
      os_frames    = 2'd1;
      rebuild_map();
      result_q.delete();
      mismatches   = 0;
      result_index = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_MOD_COUNT) begin
          mod_count = cfg_ch.data[NMOD_W-1:0];
        end else begin
          os_frames = cfg_ch.data[OSF_W-1:0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(apply_command(func_e'(in_ch.func),
                                         {in_ch.segment, in_ch.page},
                                         in_ch.module_sel,
                                         in_ch.frame_sel[FRAME_W-1:0]));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_LIMIT) begin
            $display("ERROR: result word %0d arrived with nothing expected: status %0d "
                     , result_index, out_ch.status,
                     "module %0d frame %0d", out_ch.hit_module, out_ch.hit_frame);
          end
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status || out_ch.hit_module !== want.hit_module ||
              out_ch.hit_frame !== want.hit_frame) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT) begin
              $display("ERROR: result word %0d: expected status %0d module %0d frame %0d, ",
                       result_index, want.status, want.hit_module, want.hit_frame,
                       "got status %0d module %0d frame %0d",
                       out_ch.status, out_ch.hit_module, out_ch.hit_frame);
            end
          end
        end
        result_index++;
      end
      fail_count_o <= mismatches;
      pending_o    <= result_q.size();
    end
  end

endmodule

>>> verif/tb_segment_page_frame_map_core.sv
// ----------------------------------------------------------------------------
// Segment/page frame map core testbench
// Drives directed and random lookup, map, reinitialize and unused-code
// words under a range of module and OS frame counts, with random gaps on
// both command and result channels; a separate checker predicts and
// compares every result word.
module tb_segment_page_frame_map_core;
  import spfm_pkg::*;

  localparam int unsigned LATENCY        = MODULES;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 9;
  localparam int unsigned PHASE_WORDS    = 205;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned cmd_count [4];
  int unsigned setting_count;
  int unsigned span;
  bit          send_rush;
  bit          recv_rush;
  logic [TAG_W-1:0] recent_tag [8];

  spfm_in_if  in_ch ();
  spfm_out_if out_ch ();
  spfm_cfg_if cfg_ch ();

  segment_page_frame_map_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  spfm_map_checker map_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk = ~clk;

  function automatic logic [3:0] any4();
    return 4'($urandom_range(0, 15));
  endfunction

  // Valid stays high from one word to the next when no gap is drawn.
  task automatic send_command(func_e func, logic [3:0] seg, logic [3:0] pg,
                              logic [3:0] mod, logic [3:0] frm);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_rush = !send_rush;
    gap = send_rush ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.segment    <= seg;
    in_ch.page       <= pg;
    in_ch.module_sel <= mod;
    in_ch.frame_sel  <= frm;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cmd_count[func]++;
  endtask

  // Registers change only once every result word has come back.
  task automatic set_regs(logic [NMOD_W-1:0] nmod, logic [OSF_W-1:0] osf);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_MOD_COUNT;
    cfg_ch.data  <= nmod;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    // The upper data bits are don't-care for the OS frame count.
    cfg_ch.index <= CFG_OS_FRAMES;
    cfg_ch.data  <= {3'($urandom_range(0, 7)), osf};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    span = (nmod > MODULES) ? MODULES : int'(nmod);
    setting_count++;
  endtask

  task automatic random_phase(int unsigned words);
    int unsigned      pick;
    logic [3:0]       seg;
    logic [3:0]       pg;
    logic [3:0]       mod;
    logic [TAG_W-1:0] tag;
    repeat (words) begin
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
        // Most lookups aim at recently mapped tags so that hits are common.
        if ($urandom_range(0, 9) < 6) tag = recent_tag[$urandom_range(0, 7)];
        else tag = TAG_W'($urandom_range(0, 255));
        send_command(FUNC_LOOKUP, tag[7:4], tag[3:0], any4(), any4());
      end else if (pick < 94) begin
        // A narrow segment range makes duplicate tags across frames likely.
        seg = $urandom_range(0, 1) ? 4'($urandom_range(0, 1)) : any4();
        pg  = any4();
        if (span != 0 && $urandom_range(0, 9) < 8) mod = 4'($urandom_range(0, span - 1));
        else mod = any4();
        recent_tag[$urandom_range(0, 7)] = {seg, pg};
        send_command(FUNC_MAP, seg, pg, mod, any4());
      end else if (pick < 97) begin
        send_command(FUNC_REINIT, any4(), any4(), any4(), any4());
      end else begin
        send_command(FUNC_NONE, any4(), any4(), any4(), any4());
      end
    end
  endtask

  // Result side: a fresh stall is drawn for every word.
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_rush = !recv_rush;
      stall = recv_rush ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("segment_page_frame_map_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned p;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_LOOKUP;
    in_ch.segment    <= '0;
    in_ch.page       <= '0;
    in_ch.module_sel <= '0;
    in_ch.frame_sel  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_MOD_COUNT;
    cfg_ch.data      <= '0;
    for (p = 0; p < 8; p++) recent_tag[p] = '0;
    for (p = 0; p < 4; p++) cmd_count[p] = 0;
    setting_count = 0;
    span          = 1;
    send_rush     = 1'b0;
    recv_rush     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset map: one module, frame 0 of module 0 hardwired; unmapped frames read 0:0.
    send_command(FUNC_LOOKUP, 4'd0, 4'd0, any4(), any4());
    send_command(FUNC_LOOKUP, 4'd15, 4'd15, any4(), any4());
    send_command(FUNC_MAP, 4'd15, 4'd15, 4'd0, 4'd0);
    send_command(FUNC_MAP, 4'd3, 4'd5, 4'd0, 4'd9);
    send_command(FUNC_LOOKUP, 4'd3, 4'd5, any4(), any4());
    send_command(FUNC_MAP, 4'd15, 4'd15, 4'd1, 4'd7);
    send_command(FUNC_MAP, 4'd15, 4'd15, 4'd15, 4'd15);
    send_command(FUNC_MAP, 4'd15, 4'd15, 4'd0, 4'd15);
    send_command(FUNC_LOOKUP, 4'd15, 4'd15, any4(), any4());
    send_command(FUNC_NONE, any4(), any4(), any4(), any4());
    send_command(FUNC_REINIT, any4(), any4(), any4(), any4());
    send_command(FUNC_LOOKUP, 4'd15, 4'd15, any4(), any4());

    // All modules, two OS frames; duplicate tags resolve to the lowest frame.
    set_regs(5'd16, 2'd2);
    send_command(FUNC_MAP, 4'd0, 4'd1, 4'd0, 4'd1);
    send_command(FUNC_MAP, 4'd10, 4'd10, 4'd15, 4'd7);
    send_command(FUNC_MAP, 4'd10, 4'd10, 4'd9, 4'd8);
    send_command(FUNC_LOOKUP, 4'd10, 4'd10, any4(), any4());
    send_command(FUNC_REINIT, any4(), any4(), any4(), any4());
    send_command(FUNC_LOOKUP, 4'd0, 4'd1, any4(), any4());

    // No populated module at all.
    set_regs(5'd0, 2'd0);
    send_command(FUNC_LOOKUP, 4'd0, 4'd0, any4(), any4());
    send_command(FUNC_MAP, 4'd1, 4'd1, 4'd0, 4'd3);
    send_command(FUNC_REINIT, any4(), any4(), any4(), any4());

    // Module count above the module total, three OS frames.
    set_regs(5'd31, 2'd3);
    send_command(FUNC_MAP, 4'd2, 4'd2, 4'd0, 4'd2);
    send_command(FUNC_MAP, 4'd12, 4'd3, 4'd15, 4'd6);
    send_command(FUNC_LOOKUP, 4'd12, 4'd3, any4(), any4());
    send_command(FUNC_REINIT, any4(), any4(), any4(), any4());
    send_command(FUNC_LOOKUP, 4'd0, 4'd2, any4(), any4());

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_regs(5'd1, 2'd1);
        1: set_regs(5'd16, 2'd0);
        2: set_regs(5'd8, 2'd2);
        3: set_regs(5'd17, 2'd3);
        4: set_regs(5'd0, 2'd1);
        5: set_regs(5'd2, 2'd2);
        6: set_regs(5'd16, 2'd1);
        default: set_regs(5'($urandom_range(0, 31)), 2'($urandom_range(0, 3)));
      endcase
      random_phase(PHASE_WORDS);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d lookups, %0d maps, %0d reinitializations, %0d unused-code words",
             cmd_count[FUNC_LOOKUP], cmd_count[FUNC_MAP], cmd_count[FUNC_REINIT],
             cmd_count[FUNC_NONE]);
    $display("over %0d register settings, module counts 0 to 31, OS frame counts 0 to 3",
             setting_count);
    if (fail_count == 0 && pending == 0) begin
      $display("segment_page_frame_map_core test passed");
    end else begin
      $display("segment_page_frame_map_core test failed");
    end
    $finish;
  end

endmodule
